### rtl/core/vat_pkg.sv
package vat_pkg;

  localparam int MAX_PTS = 64;
  localparam int IDX_W   = 6;
  localparam int N_W     = 7;
  localparam int VTX_W   = 6;
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 24;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic KIND_ORDER = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  localparam logic [N_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [N_W-1:0] SIZE_MIN   = 7'd2;

endpackage

### rtl/core/vat_seriation_engine.sv
// Channel   Direction  Signals                      Contents
// s_axis    in         tvalid tready tdata tuser    commands: loads and reads
//                      tlast
// m_axis    out        tvalid tready tdata tuser    order words and read values
//                      tlast
// apb       in/out     psel penable pwrite paddr    matrix_size at address 0
//                      pwdata prdata pready
// The word marked last starts the ordering: a maximum scan over the matrix, a pass
// to seed the nearest table, then n-1 steps of a select pass and an update pass,
// the matrix passes paced by the single read port of the matrix memory, and then
// the sending of the order words. A read looks up the order, reads the matrix and,
// unless the result is clamped to zero, runs the bit-serial divider. Reset is
// synchronous and needs no clearing pass. A stalled output word holds the sequencer
// only where a new word must be written into the output register.
module vat_seriation_engine #(
  parameter int DIST_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // row [5:0], col [11:6], distance [DIST_BITS+11:12], zero fill above
  input  logic [((12+DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // vertex [5:0], value [21:6], zero fill above
  output logic [vat_pkg::OUT_W-1:0] m_axis_tdata,
  // kind
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DW   = DIST_BITS;
  localparam int NW   = DW + 16;
  localparam int DC_W = $clog2(NW);
  localparam int IW   = vat_pkg::IDX_W;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_FAR  = 10'b0000000010,
    S_INIT = 10'b0000000100,
    S_SEL  = 10'b0000001000,
    S_UPD  = 10'b0000010000,
    S_EMIT = 10'b0000100000,
    S_RORD = 10'b0001000000,
    S_RMAT = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_ROUT = 10'b1000000000
  } state_t;

  state_t state;

  logic [vat_pkg::N_W-1:0] matrix_size;
  logic [vat_pkg::N_W-1:0] n_use;
  logic [IW-1:0]           n_last;

  logic [DW-1:0]  gmin, gmax, runmax;
  logic           new_matrix;
  logic [IW-1:0]  far, best, p, bpos, orow, ocol, rq, cq;
  logic [DW-1:0]  bd;
  logic           found;

  logic [IW-1:0]  cnt_i, cnt_j, rd_i, rd_j;
  logic           issuing, rd_v, rd_last, scan_end, pend;

  logic [DW-1:0]  rem, span;
  logic [NW-1:0]  nq;
  logic [DC_W-1:0] dcnt;
  logic [vat_pkg::VAL_W-1:0] qval;

  logic                      out_valid, out_kind, out_last;
  logic [vat_pkg::VTX_W-1:0] out_vtx;
  logic [vat_pkg::VAL_W-1:0] out_val;

  logic [DW-1:0] mat_mem [vat_pkg::MAX_PTS*vat_pkg::MAX_PTS];
  logic [DW-1:0] mat_rdata, mat_wdata;
  logic [2*IW-1:0] mat_raddr, mat_waddr;
  logic          mat_we;

  logic [DW+IW:0] near_mem [vat_pkg::MAX_PTS];
  logic [DW+IW:0] near_rdata, near_wdata;
  logic [IW-1:0]  near_waddr;
  logic           near_we;

  logic [IW-1:0] order_mem [vat_pkg::MAX_PTS];
  logic [IW-1:0] order_rdata, order_wdata, order_raddr, order_waddr;
  logic          order_we;

  logic [IW-1:0] in_row, in_col;
  logic [DW-1:0] in_dist;
  logic          s_acc, in_range;
  logic [DW-1:0] base_min, base_max, min_n, max_n;

  logic [DW-1:0] nd;
  logic [IW-1:0] np, sel_best;
  logic          nc, take, upd_hit;

  logic [DW:0]   rem_sh;
  logic          qbit;
  logic [DW-1:0] rem_nx;
  logic [NW-1:0] q_fin;
  logic          cfg_wr;

  assign in_row  = s_axis_tdata[IW-1:0];
  assign in_col  = s_axis_tdata[2*IW-1:IW];
  assign in_dist = s_axis_tdata[2*IW+DW-1:2*IW];

  assign n_use = (matrix_size < vat_pkg::SIZE_MIN) ? vat_pkg::SIZE_MIN :
                 (matrix_size > vat_pkg::N_W'(vat_pkg::MAX_PTS)) ?
                 vat_pkg::N_W'(vat_pkg::MAX_PTS) : matrix_size;
  assign n_last = IW'(n_use - 7'd1);

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign in_range = ({1'b0, in_row} < n_use) && ({1'b0, in_col} < n_use);

  assign base_min = new_matrix ? {DW{1'b1}} : gmin;
  assign base_max = new_matrix ? {DW{1'b0}} : gmax;
  assign min_n = (in_range && in_dist < base_min) ? in_dist : base_min;
  assign max_n = (in_range && in_dist > base_max) ? in_dist : base_max;

  assign nc = near_rdata[DW+IW];
  assign nd = near_rdata[DW+IW-1:IW];
  assign np = near_rdata[IW-1:0];
  assign take = !nc && (!found || nd < bd || (nd == bd && np < bpos));
  assign sel_best = take ? rd_j : best;
  assign upd_hit = !nc && (mat_rdata < nd);

  assign rem_sh = {rem, nq[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, span});
  assign rem_nx = qbit ? DW'(rem_sh - {1'b0, span}) : rem_sh[DW-1:0];
  assign q_fin  = {nq[NW-2:0], qbit};

  always_comb begin
    unique case (state)
      S_FAR:   scan_end = (cnt_i == n_last) && (cnt_j == n_last);
      S_RORD:  scan_end = (cnt_j == 6'd1);
      S_RMAT:  scan_end = 1'b1;
      default: scan_end = (cnt_j == n_last);
    endcase
  end

  always_comb begin
    unique case (state)
      S_FAR:   mat_raddr = {cnt_i, cnt_j};
      S_INIT:  mat_raddr = {far, cnt_j};
      S_UPD:   mat_raddr = {best, cnt_j};
      default: mat_raddr = {orow, ocol};
    endcase
  end

  assign mat_we    = s_acc && (s_axis_tuser == vat_pkg::CMD_LOAD) && in_range;
  assign mat_waddr = {in_row, in_col};
  assign mat_wdata = in_dist;

  assign near_we    = rd_v && ((state == S_INIT) ||
                               ((state == S_UPD) && (upd_hit || rd_j == best)));
  assign near_waddr = rd_j;
  assign near_wdata = (state == S_INIT) ? {(rd_j == far), mat_rdata, {IW{1'b0}}} :
                      (rd_j == best) ? {1'b1, nd, np} : {1'b0, mat_rdata, p};

  assign order_we    = rd_v && rd_last && ((state == S_INIT) || (state == S_SEL));
  assign order_waddr = (state == S_INIT) ? {IW{1'b0}} : p;
  assign order_wdata = (state == S_INIT) ? far : sel_best;
  assign order_raddr = (state == S_RORD) ? ((cnt_j == 6'd0) ? rq : cq) : cnt_j;

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_rdata <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (near_we) begin
      near_mem[near_waddr] <= near_wdata;
    end
    near_rdata <= near_mem[cnt_j];
  end

  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rdata <= order_mem[order_raddr];
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, matrix_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      matrix_size <= vat_pkg::SIZE_RESET;
      gmin        <= {DW{1'b1}};
      gmax        <= {DW{1'b0}};
      far         <= '0;
      new_matrix  <= 1'b0;
      issuing     <= 1'b0;
      rd_v        <= 1'b0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == 1'b0) begin
        matrix_size <= pwdata[vat_pkg::N_W-1:0];
      end
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (issuing) begin
        rd_v    <= 1'b1;
        rd_i    <= cnt_i;
        rd_j    <= cnt_j;
        rd_last <= scan_end;
        if (scan_end) begin
          issuing <= 1'b0;
        end else if (state == S_FAR && cnt_j == n_last) begin
          cnt_j <= '0;
          cnt_i <= cnt_i + 6'd1;
        end else begin
          cnt_j <= cnt_j + 6'd1;
        end
      end else begin
        rd_v <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            cnt_i <= '0;
            cnt_j <= '0;
            if (s_axis_tuser == vat_pkg::CMD_READ) begin
              rq <= in_row;
              cq <= in_col;
              if (in_range) begin
                issuing <= 1'b1;
                state   <= S_RORD;
              end else begin
                orow  <= '0;
                qval  <= '0;
                state <= S_ROUT;
              end
            end else begin
              new_matrix <= 1'b0;
              gmin <= min_n;
              gmax <= max_n;
              if (s_axis_tlast) begin
                runmax  <= min_n;
                far     <= '0;
                issuing <= 1'b1;
                state   <= S_FAR;
              end
            end
          end
        end
        S_FAR: begin
          if (rd_v) begin
            if (rd_i != rd_j && mat_rdata > runmax) begin
              runmax <= mat_rdata;
              far    <= rd_i;
            end
            if (rd_last) begin
              cnt_j   <= '0;
              issuing <= 1'b1;
              state   <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (rd_v && rd_last) begin
            p       <= 6'd1;
            found   <= 1'b0;
            cnt_j   <= '0;
            issuing <= 1'b1;
            state   <= S_SEL;
          end
        end
        S_SEL: begin
          if (rd_v) begin
            if (take) begin
              best  <= rd_j;
              bd    <= nd;
              bpos  <= np;
              found <= 1'b1;
            end
            if (rd_last) begin
              cnt_j   <= '0;
              issuing <= 1'b1;
              state   <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (rd_v && rd_last) begin
            cnt_j <= '0;
            if (p == n_last) begin
              pend  <= 1'b0;
              state <= S_EMIT;
            end else begin
              p       <= p + 6'd1;
              found   <= 1'b0;
              issuing <= 1'b1;
              state   <= S_SEL;
            end
          end
        end
        S_EMIT: begin
          if (pend) begin
            pend      <= 1'b0;
            out_valid <= 1'b1;
            out_kind  <= vat_pkg::KIND_ORDER;
            out_vtx   <= order_rdata;
            out_val   <= '0;
            out_last  <= (cnt_j == n_last);
            if (cnt_j == n_last) begin
              new_matrix <= 1'b1;
              state      <= S_IDLE;
            end else begin
              cnt_j <= cnt_j + 6'd1;
            end
          end else if (!out_valid) begin
            pend <= 1'b1;
          end
        end
        S_RORD: begin
          if (rd_v) begin
            if (rd_j == 6'd0) begin
              orow <= order_rdata;
            end else begin
              ocol <= order_rdata;
            end
            if (rd_last) begin
              issuing <= 1'b1;
              state   <= S_RMAT;
            end
          end
        end
        S_RMAT: begin
          if (rd_v) begin
            if (gmax <= gmin || mat_rdata <= gmin) begin
              qval  <= '0;
              state <= S_ROUT;
            end else begin
              rem   <= '0;
              nq    <= {DW'(mat_rdata - gmin), 16'd0};
              span  <= gmax - gmin;
              dcnt  <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem  <= rem_nx;
          nq   <= q_fin;
          dcnt <= dcnt + DC_W'(1);
          if (dcnt == DC_W'(NW-1)) begin
            qval  <= (|q_fin[NW-1:16]) ? 16'hFFFF : q_fin[15:0];
            state <= S_ROUT;
          end
        end
        S_ROUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_kind  <= vat_pkg::KIND_VALUE;
            out_vtx   <= orow;
            out_val   <= qval;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_val, out_vtx};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

### rtl/core/vat_checker.sv
module vat_checker (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [vat_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_order_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == vat_pkg::KIND_ORDER |-> m_axis_tdata[21:6] == 16'd0)
    else $error("order word carries a value");

  a_read_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == vat_pkg::KIND_VALUE |-> m_axis_tlast)
    else $error("read result without last");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == vat_pkg::CMD_READ
    |=> !s_axis_tready)
    else $error("read accepted without working on it");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind vat_seriation_engine vat_checker u_vat_checker (.*);

### verif/vat_seriation_engine_tb.sv
module vat_seriation_engine_tb;

  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE = 64;
  localparam int RING = 256;

  typedef struct packed {
    logic                       kind;
    logic [vat_pkg::VTX_W-1:0]  vertex;
    logic [vat_pkg::VAL_W-1:0]  value;
    logic                       last;
  } word_t;

  typedef struct packed {
    logic                       cmd;
    logic [vat_pkg::IDX_W-1:0]  row;
    logic [vat_pkg::IDX_W-1:0]  col;
    logic [15:0]                distance;
    logic                       last;
    logic                       typed;
    word_t                      want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [vat_pkg::OUT_W-1:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vat_seriation_engine u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the engine state.
  logic [15:0]               dist_mem [vat_pkg::MAX_PTS*vat_pkg::MAX_PTS];
  logic [vat_pkg::VTX_W-1:0] order_mem [vat_pkg::MAX_PTS];
  logic                      picked [vat_pkg::MAX_PTS];
  logic [15:0]               near_dist [vat_pkg::MAX_PTS];
  logic [vat_pkg::VTX_W-1:0] near_pos [vat_pkg::MAX_PTS];
  logic [15:0]               dist_lo;
  logic [15:0]               dist_hi;
  logic [vat_pkg::N_W-1:0]   size_reg;
  logic                      fresh_matrix;

  word_t exp_words [RING];
  int    exp_head = 0;
  int    exp_tail = 0;
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    send_idle = 0;
  int    recv_idle = 0;
  bit    hold_pending = 0;
  int    hold_left = 0;

  function automatic void queue_word(word_t w);
    exp_words[exp_tail % RING] = w;
    exp_tail++;
  endfunction

  function automatic int points_in_use();
    if (size_reg < vat_pkg::SIZE_MIN) return 2;
    if (size_reg > vat_pkg::N_W'(vat_pkg::MAX_PTS)) return vat_pkg::MAX_PTS;
    return int'(size_reg);
  endfunction

  function automatic logic [15:0] dist_at(int r, int c);
    return dist_mem[r*vat_pkg::MAX_PTS + c];
  endfunction

  function automatic logic [vat_pkg::VAL_W-1:0] scaled(logic [15:0] d);
    longint unsigned span, q;
    if (dist_hi <= dist_lo || d <= dist_lo) return '0;
    span = dist_hi - dist_lo;
    q = ((longint'(d) - dist_lo) << 16) / span;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void seriate(int n);
    logic [15:0] peak;
    int start, best;
    bit found;
    peak = dist_lo;
    start = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j && dist_at(i, j) > peak) begin
          peak = dist_at(i, j);
          start = i;
        end
    for (int j = 0; j < vat_pkg::MAX_PTS; j++) picked[j] = 1'b0;
    order_mem[0] = vat_pkg::VTX_W'(start);
    picked[start] = 1'b1;
    for (int j = 0; j < n; j++) begin
      near_dist[j] = dist_at(start, j);
      near_pos[j] = '0;
    end
    for (int p = 1; p < n; p++) begin
      found = 0;
      best = 0;
      for (int j = 0; j < n; j++) begin
        if (picked[j]) continue;
        if (!found || near_dist[j] < near_dist[best] ||
            (near_dist[j] == near_dist[best] && near_pos[j] < near_pos[best])) begin
          best = j;
          found = 1;
        end
      end
      order_mem[p] = vat_pkg::VTX_W'(best);
      picked[best] = 1'b1;
      for (int j = 0; j < n; j++)
        if (!picked[j] && dist_at(best, j) < near_dist[j]) begin
          near_dist[j] = dist_at(best, j);
          near_pos[j] = vat_pkg::VTX_W'(p);
        end
    end
  endfunction

  // Applies one accepted command to the shadow state and queues its words.
  task automatic predict_command(logic cmd, int r, int c, logic [15:0] d, logic last);
    int n;
    word_t w;
    n = points_in_use();
    if (cmd == vat_pkg::CMD_READ) begin
      w.kind = vat_pkg::KIND_VALUE;
      w.last = 1'b1;
      if (r >= n || c >= n) begin
        w.vertex = '0;
        w.value = '0;
      end else begin
        w.vertex = order_mem[r];
        w.value = scaled(dist_at(int'(order_mem[r]), int'(order_mem[c])));
      end
      queue_word(w);
      return;
    end
    if (fresh_matrix) begin
      dist_lo = 16'hFFFF;
      dist_hi = '0;
      fresh_matrix = 1'b0;
    end
    if (r < n && c < n) begin
      dist_mem[r*vat_pkg::MAX_PTS + c] = d;
      if (d < dist_lo) dist_lo = d;
      if (d > dist_hi) dist_hi = d;
    end
    if (!last) return;
    seriate(n);
    fresh_matrix = 1'b1;
    for (int k = 0; k < n; k++) begin
      w.kind = vat_pkg::KIND_ORDER;
      w.vertex = order_mem[k];
      w.value = '0;
      w.last = (k == n-1);
      queue_word(w);
    end
  endtask

  task automatic send_word(logic cmd, int r, int c, logic [15:0] d, logic last,
                           bit typed = 0, word_t want = '0);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tlast <= last;
    s_axis_tdata <= {4'b0, d, c[5:0], r[5:0]};
    do @(posedge clk); while (!s_axis_tready);
    predict_command(cmd, r, c, d, last);
    if (typed) begin
      exp_words[(exp_tail - 1) % RING] = want;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (exp_head == exp_tail);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [31:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    size_reg = v[vat_pkg::N_W-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != {25'b0, v[vat_pkg::N_W-1:0]}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("matrix_size readback: expected %0d got %0d",
                 v[vat_pkg::N_W-1:0], prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_dist();
    return ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
  endfunction

  task automatic load_matrix(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (n < vat_pkg::MAX_PTS && $urandom_range(9) == 0)
          send_word(vat_pkg::CMD_LOAD, $urandom_range(vat_pkg::MAX_PTS-1, n),
                    $urandom_range(vat_pkg::MAX_PTS-1), 16'($urandom), 1'b0);
        send_word(vat_pkg::CMD_LOAD, i, j, pick_dist(), (i == n-1 && j == n-1));
      end
  endtask

  task automatic read_some(int n, int count);
    for (int k = 0; k < count; k++) begin
      if (n < vat_pkg::MAX_PTS && $urandom_range(4) == 0)
        send_word(vat_pkg::CMD_READ, $urandom_range(vat_pkg::MAX_PTS-1, n),
                  $urandom_range(vat_pkg::MAX_PTS-1), 16'($urandom), 1'($urandom));
      else
        send_word(vat_pkg::CMD_READ, $urandom_range(n-1), $urandom_range(n-1),
                  16'($urandom), 1'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tlast};
      if (exp_head == exp_tail) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = exp_words[exp_head % RING];
        exp_head++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: expected kind %0d vertex %0d value %0d last %0d,",
                      " got kind %0d vertex %0d value %0d last %0d"},
                     want.kind, want.vertex, want.value, want.last,
                     got.kind, got.vertex, got.value, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** vat_seriation_engine: FAILED **");
      $finish;
    end
  end

  dir_row_t dir_tab [12];

  initial begin
    int n;
    int done;
    dir_tab = '{
      '{vat_pkg::CMD_LOAD, 0, 0, 16'd0, 1'b0, 1'b0, '0},
      '{vat_pkg::CMD_LOAD, 0, 1, 16'hFFFF, 1'b0, 1'b0, '0},
      '{vat_pkg::CMD_LOAD, 1, 0, 16'd0, 1'b0, 1'b0, '0},
      '{vat_pkg::CMD_LOAD, 1, 1, 16'd5, 1'b1, 1'b0, '0},
      '{vat_pkg::CMD_READ, 0, 1, 16'd0, 1'b0, 1'b1,
        '{vat_pkg::KIND_VALUE, 6'd0, 16'hFFFF, 1'b1}},
      '{vat_pkg::CMD_READ, 1, 0, 16'd0, 1'b0, 1'b1,
        '{vat_pkg::KIND_VALUE, 6'd1, 16'd0, 1'b1}},
      '{vat_pkg::CMD_READ, 63, 63, 16'hFFFF, 1'b0, 1'b1,
        '{vat_pkg::KIND_VALUE, 6'd0, 16'd0, 1'b1}},
      '{vat_pkg::CMD_READ, 0, 0, 16'd0, 1'b1, 1'b1,
        '{vat_pkg::KIND_VALUE, 6'd0, 16'd0, 1'b1}},
      '{vat_pkg::CMD_LOAD, 63, 2, 16'h1234, 1'b0, 1'b0, '0},
      '{vat_pkg::CMD_LOAD, 5, 5, 16'hAAAA, 1'b1, 1'b0, '0},
      '{vat_pkg::CMD_READ, 0, 1, 16'd0, 1'b0, 1'b1,
        '{vat_pkg::KIND_VALUE, 6'd0, 16'd0, 1'b1}},
      '{vat_pkg::CMD_READ, 1, 1, 16'h5555, 1'b0, 1'b1,
        '{vat_pkg::KIND_VALUE, 6'd1, 16'd0, 1'b1}}
    };
    for (int i = 0; i < vat_pkg::MAX_PTS*vat_pkg::MAX_PTS; i++) dist_mem[i] = '0;
    for (int i = 0; i < vat_pkg::MAX_PTS; i++) order_mem[i] = '0;
    dist_lo = 16'hFFFF;
    dist_hi = '0;
    size_reg = vat_pkg::SIZE_RESET;
    fresh_matrix = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_size(32'd1);
    foreach (dir_tab[i])
      send_word(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].distance,
                dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 13 : (ph == 1) ? 73 : 0;
      recv_idle = (ph == 0) ? 73 : (ph == 1) ? 13 : 0;
      done = 0;
      while (done < 75) begin
        case ($urandom_range(5))
          0: write_size(32'($urandom_range(1)));
          default: write_size(32'($urandom_range(8, 2)));
        endcase
        n = points_in_use();
        load_matrix(n);
        if (ph == 2 && done == 0) begin
          hold_pending = 1;
          read_some(n, 24);
        end else begin
          read_some(n, $urandom_range(12, 6));
        end
        done += n*n + 9;
      end
    end

    write_size(32'd127);

    drain();
    if (mismatches == 0 && exp_head == exp_tail) begin
      $display("** vat_seriation_engine: PASSED **");
    end else begin
      $display("** vat_seriation_engine: FAILED **");
    end
    $finish;
  end

endmodule
